/* hw/rtl/row_column_field_size_unit_macros.svh */
// ============================================================================
// Row column field size unit: assertion macros
// Shared concurrent assertion forms used by the block's checker.
// ============================================================================
`ifndef ROW_COLUMN_FIELD_SIZE_UNIT_MACROS_SVH
`define ROW_COLUMN_FIELD_SIZE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcfs assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RCFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcfs assertion failed");

`endif

/* hw/rtl/rcfs_pkg.sv */
// ============================================================================
// Row column field size package
// Type codes, word layouts and the packed decimal size helper.
// ============================================================================
package rcfs_pkg;

    // Column type codes.
    localparam logic [7:0] TYPE_DECIMAL     = 8'd0;
    localparam logic [7:0] TYPE_TINY        = 8'd1;
    localparam logic [7:0] TYPE_SHORT       = 8'd2;
    localparam logic [7:0] TYPE_LONG        = 8'd3;
    localparam logic [7:0] TYPE_FLOAT       = 8'd4;
    localparam logic [7:0] TYPE_DOUBLE      = 8'd5;
    localparam logic [7:0] TYPE_NULL        = 8'd6;
    localparam logic [7:0] TYPE_TIMESTAMP   = 8'd7;
    localparam logic [7:0] TYPE_LONGLONG    = 8'd8;
    localparam logic [7:0] TYPE_INT24       = 8'd9;
    localparam logic [7:0] TYPE_DATE        = 8'd10;
    localparam logic [7:0] TYPE_TIME        = 8'd11;
    localparam logic [7:0] TYPE_DATETIME    = 8'd12;
    localparam logic [7:0] TYPE_YEAR        = 8'd13;
    localparam logic [7:0] TYPE_NEWDATE     = 8'd14;
    localparam logic [7:0] TYPE_VARCHAR     = 8'd15;
    localparam logic [7:0] TYPE_BIT         = 8'd16;
    localparam logic [7:0] TYPE_NEWDECIMAL  = 8'd246;
    localparam logic [7:0] TYPE_ENUM        = 8'd247;
    localparam logic [7:0] TYPE_SET         = 8'd248;
    localparam logic [7:0] TYPE_TINY_BLOB   = 8'd249;
    localparam logic [7:0] TYPE_MEDIUM_BLOB = 8'd250;
    localparam logic [7:0] TYPE_LONG_BLOB   = 8'd251;
    localparam logic [7:0] TYPE_BLOB        = 8'd252;
    localparam logic [7:0] TYPE_VAR_STRING  = 8'd253;
    localparam logic [7:0] TYPE_STRING      = 8'd254;
    localparam logic [7:0] TYPE_GEOMETRY    = 8'd255;

    // Blob length prefix widths carried in the metadata word.
    localparam logic [15:0] PREFIX_ONE   = 16'd1;
    localparam logic [15:0] PREFIX_TWO   = 16'd2;
    localparam logic [15:0] PREFIX_THREE = 16'd3;
    localparam logic [15:0] PREFIX_FOUR  = 16'd4;

    localparam logic [31:0] LEN_INVALID = 32'hFFFF_FFFF;

    // Digits per four-byte group of a packed decimal, and the reciprocal
    // used to divide an 8-bit digit count by it: floor(x * 57 / 512).
    localparam int unsigned DIG_PER_GROUP = 9;
    localparam int unsigned RECIP_MUL     = 57;
    localparam int unsigned RECIP_SHIFT   = 9;

    typedef struct packed {
        logic [7:0]  column_type;
        logic [15:0] metadata;
        logic [31:0] prefix_bytes;
    } rcfs_item_t;

    typedef struct packed {
        logic [31:0] field_length;
        logic [1:0]  metadata_size;
        logic        unknown_type;
    } rcfs_result_t;

    // Bytes taken by the digits left over after whole groups of nine.
    function automatic logic [2:0] leftover_bytes(input logic [3:0] digits);
        logic [2:0] bytes;
        case (digits)
            4'd0:    bytes = 3'd0;
            4'd1:    bytes = 3'd1;
            4'd2:    bytes = 3'd1;
            4'd3:    bytes = 3'd2;
            4'd4:    bytes = 3'd2;
            4'd5:    bytes = 3'd3;
            4'd6:    bytes = 3'd3;
            4'd7:    bytes = 3'd4;
            4'd8:    bytes = 3'd4;
            4'd9:    bytes = 3'd4;
            default: bytes = 3'd0;
        endcase
        return bytes;
    endfunction

    // Storage bytes for a run of decimal digits (at most 255 digits).
    function automatic logic [7:0] decimal_bytes(input logic [7:0] digits);
        logic [13:0] prod;
        logic [4:0]  groups;
        logic [7:0]  rem;
        prod   = 14'(digits) * 14'(RECIP_MUL);
        groups = prod[RECIP_SHIFT +: 5];
        rem    = digits - 8'(groups) * 8'(DIG_PER_GROUP);
        return {1'b0, groups, 2'b00} + 8'(leftover_bytes(rem[3:0]));
    endfunction

endpackage

/* hw/rtl/rcfs_if.sv */
// ============================================================================
// Row column field size channels
// Valid/ready channels for column descriptor words and result words.
// ============================================================================

// Column descriptor channel.
interface rcfs_col_if;
    logic        valid;
    logic        ready;
    logic [7:0]  column_type;
    logic [15:0] metadata;
    logic [31:0] prefix_bytes;

    modport source (output valid, output column_type, output metadata,
                    output prefix_bytes, input ready);
    modport sink   (input valid, input column_type, input metadata,
                    input prefix_bytes, output ready);
endinterface

// Field size result channel.
interface rcfs_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] field_length;
    logic [1:0]  metadata_size;
    logic        unknown_type;

    modport source (output valid, output field_length, output metadata_size,
                    output unknown_type, input ready);
    modport sink   (input valid, input field_length, input metadata_size,
                    input unknown_type, output ready);
endinterface

/* hw/rtl/rcfs_length_calc.sv */
// ============================================================================
// Row column field size calculator
// Combinational decode of one column descriptor into its field length,
// metadata byte count and unknown-type flag.
// ============================================================================
module rcfs_length_calc (
    input  rcfs_pkg::rcfs_item_t   item,
    output rcfs_pkg::rcfs_result_t res
);

    logic [7:0]  md_lo;
    logic [7:0]  md_hi;
    logic [7:0]  b0;
    logic [15:0] w16;
    logic [7:0]  int_digits;
    logic [7:0]  dec_len;
    logic [31:0] blob_len;

    assign md_lo = item.metadata[7:0];
    assign md_hi = item.metadata[15:8];
    assign b0    = item.prefix_bytes[7:0];
    assign w16   = item.prefix_bytes[15:0];

    // Packed decimal: integer digits and scale digits sized separately.
    assign int_digits = md_lo - md_hi;
    assign dec_len    = rcfs_pkg::decimal_bytes(int_digits)
                      + rcfs_pkg::decimal_bytes(md_hi);

    // Blob family: length prefix of one to four bytes ahead of the data.
    always_comb
    begin
        case (item.metadata)
            rcfs_pkg::PREFIX_ONE:   blob_len = 32'(b0) + 32'd1;
            rcfs_pkg::PREFIX_TWO:   blob_len = 32'(w16) + 32'd2;
            rcfs_pkg::PREFIX_THREE: blob_len = 32'(item.prefix_bytes[23:0]) + 32'd3;
            rcfs_pkg::PREFIX_FOUR:  blob_len = item.prefix_bytes + 32'd4;
            default:                blob_len = 32'd0;
        endcase
    end

    // Field length and flag by type code.
    always_comb
    begin
        res.field_length = 32'd0;
        res.unknown_type = 1'b0;
        case (item.column_type)
            rcfs_pkg::TYPE_VAR_STRING, rcfs_pkg::TYPE_DECIMAL,
            rcfs_pkg::TYPE_FLOAT, rcfs_pkg::TYPE_DOUBLE:
                res.field_length = 32'(item.metadata);
            rcfs_pkg::TYPE_NEWDECIMAL:
            begin
                if (md_hi > md_lo)
                begin
                    res.field_length = rcfs_pkg::LEN_INVALID;
                    res.unknown_type = 1'b1;
                end
                else
                begin
                    res.field_length = 32'(dec_len);
                end
            end
            rcfs_pkg::TYPE_ENUM, rcfs_pkg::TYPE_SET, rcfs_pkg::TYPE_STRING:
            begin
                // The low metadata byte holds the real type of the column.
                if (md_lo == rcfs_pkg::TYPE_ENUM || md_lo == rcfs_pkg::TYPE_SET)
                    res.field_length = 32'(md_hi);
                else
                    res.field_length = 32'(b0) + 32'd1;
            end
            rcfs_pkg::TYPE_YEAR, rcfs_pkg::TYPE_TINY:
                res.field_length = 32'd1;
            rcfs_pkg::TYPE_SHORT:
                res.field_length = 32'd2;
            rcfs_pkg::TYPE_INT24, rcfs_pkg::TYPE_DATE, rcfs_pkg::TYPE_TIME,
            rcfs_pkg::TYPE_NEWDATE:
                res.field_length = 32'd3;
            rcfs_pkg::TYPE_LONG, rcfs_pkg::TYPE_TIMESTAMP:
                res.field_length = 32'd4;
            rcfs_pkg::TYPE_LONGLONG, rcfs_pkg::TYPE_DATETIME:
                res.field_length = 32'd8;
            rcfs_pkg::TYPE_NULL:
                res.field_length = 32'd0;
            rcfs_pkg::TYPE_BIT:
                res.field_length = 32'(md_hi) + 32'(md_lo != 8'd0);
            rcfs_pkg::TYPE_VARCHAR:
            begin
                // Columns longer than 255 bytes use a two-byte length prefix.
                if (md_hi != 8'd0)
                    res.field_length = 32'(w16) + 32'd2;
                else
                    res.field_length = 32'(b0) + 32'd1;
            end
            rcfs_pkg::TYPE_TINY_BLOB, rcfs_pkg::TYPE_MEDIUM_BLOB,
            rcfs_pkg::TYPE_LONG_BLOB, rcfs_pkg::TYPE_BLOB,
            rcfs_pkg::TYPE_GEOMETRY:
                res.field_length = blob_len;
            default:
            begin
                res.field_length = rcfs_pkg::LEN_INVALID;
                res.unknown_type = 1'b1;
            end
        endcase
    end

    // Metadata bytes carried by the column type.
    always_comb
    begin
        case (item.column_type)
            rcfs_pkg::TYPE_FLOAT, rcfs_pkg::TYPE_DOUBLE, rcfs_pkg::TYPE_BLOB,
            rcfs_pkg::TYPE_GEOMETRY:
                res.metadata_size = 2'd1;
            rcfs_pkg::TYPE_VARCHAR, rcfs_pkg::TYPE_BIT, rcfs_pkg::TYPE_NEWDECIMAL,
            rcfs_pkg::TYPE_VAR_STRING, rcfs_pkg::TYPE_STRING:
                res.metadata_size = 2'd2;
            default:
                res.metadata_size = 2'd0;
        endcase
    end

endmodule

/* hw/rtl/row_column_field_size_unit.sv */
// ============================================================================
// Row column field size unit
// Streams column descriptors and returns each field's row-image byte length.
// ============================================================================
// The unit accepts one column descriptor word per clock and returns one result
// word per descriptor, in order. A word is captured in the input register,
// decoded by a single level of combinational logic and held in the output
// register, which presents its result. Sustained throughput is one word per
// cycle, since each stage advances whenever the stage after it is empty or
// draining; it drops only while the result channel holds ready low. The
// result register decouples the two sides: while a result waits, one more
// descriptor can still be taken into an empty input register.
module row_column_field_size_unit (
    input  logic         clk,
    input  logic         rst_n,
    rcfs_col_if.sink     column,
    rcfs_res_if.source   result
);

    logic                   stage_valid_reg;
    rcfs_pkg::rcfs_item_t   stage_item_reg;
    logic                   out_valid_reg;
    rcfs_pkg::rcfs_result_t out_data_reg;
    rcfs_pkg::rcfs_result_t calc_res;
    logic                   out_take;
    logic                   stage_take;

    // Each stage advances when the stage after it is empty or draining.
    assign out_take     = !out_valid_reg || result.ready;
    assign stage_take   = !stage_valid_reg || out_take;
    assign column.ready = stage_take;

    rcfs_length_calc u_calc (
        .item (stage_item_reg),
        .res  (calc_res)
    );

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (stage_take)
                stage_valid_reg <= column.valid;
            if (out_take)
                out_valid_reg <= stage_valid_reg;
        end
    end

    // Payload registers load only with a valid word.
    always_ff @(posedge clk)
    begin
        if (stage_take && column.valid)
        begin
            stage_item_reg.column_type  <= column.column_type;
            stage_item_reg.metadata     <= column.metadata;
            stage_item_reg.prefix_bytes <= column.prefix_bytes;
        end
        if (out_take && stage_valid_reg)
            out_data_reg <= calc_res;
    end

    assign result.valid         = out_valid_reg;
    assign result.field_length  = out_data_reg.field_length;
    assign result.metadata_size = out_data_reg.metadata_size;
    assign result.unknown_type  = out_data_reg.unknown_type;

endmodule

/* hw/rtl/rcfs_checker.sv */
// ============================================================================
// Row column field size checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
`include "row_column_field_size_unit_macros.svh"

module rcfs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] field_length,
    input logic [1:0]  metadata_size,
    input logic        unknown_type
);

    logic stalled;

    assign stalled = out_valid && !out_ready;

    // A stalled result word keeps its valid and its field length.
    `RCFS_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_valid && $stable(field_length))

    // A flagged word always reports an all-ones length.
    `RCFS_ASSERT_NOW(a_flag_len, clk, rst_n, out_valid && unknown_type, field_length == 32'hFFFF_FFFF)

    // No column type carries three metadata bytes.
    `RCFS_ASSERT_NOW(a_meta_range, clk, rst_n, out_valid, metadata_size != 2'd3)

    // A flagged word is an unknown type or a bad decimal, never a type with one metadata byte.
    `RCFS_ASSERT_NOW(a_flag_meta, clk, rst_n, out_valid && unknown_type, metadata_size != 2'd1)

endmodule

bind row_column_field_size_unit rcfs_checker u_rcfs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .field_length  (result.field_length),
    .metadata_size (result.metadata_size),
    .unknown_type  (result.unknown_type)
);
